>>> sv/gemm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemm_pkg: shared types and constants
// Command codes, operand widths and the per-cycle row step passed down the
// chain of column cells.
// ----------------------------------------------------------------------------
package gemm_pkg;

   localparam int OPND_W = 8;
   localparam int ACC_W  = 32;
   localparam int IDX_W  = 16;
   localparam int FIELD_ROWS = 8;
   localparam int FIELD_COLS = 16;

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_COMP  = 2'd1,
      CMD_PANEL = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   localparam logic [0:0] CSR_FAST   = 1'b0;
   localparam logic [0:0] CSR_DIGEST = 1'b1;

   // One row of work handed from cell to cell.
   typedef struct packed {
      logic              valid;
      cmd_type           cmd;
      logic              fast;
      logic [15:0]       a_pair;     // two A bytes of this row, k=0 low
      logic [ACC_W-1:0]  comp_value;
      logic [4:0]        comp_col;
      logic              comp_ok;
      logic              last;       // last row of the item
      logic [ACC_W-1:0]  xor_acc;    // running XOR toward the chain end
   } step_type;

   // One k product: a magnitude/raw times signed b.
   function automatic logic signed [16:0] lane_mul(input logic [7:0] a,
                                                    input logic [7:0] b,
                                                    input logic fast);
      logic signed [8:0]  sa;
      logic signed [8:0]  sb;
      logic signed [8:0]  ua;
      logic signed [17:0] p;
      sa = $signed({a[7], a});
      sb = $signed({b[7], b});
      if (fast) begin
         ua = $signed({1'b0, a});
      end else if (sa < 0) begin
         ua = -sa;
         sb = (b == 8'h80) ? sb : -sb;
      end else begin
         ua = sa;
      end
      p = ua * sb;
      lane_mul = p[16:0];
   endfunction

   function automatic logic [31:0] sat16_ext(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         sat16_ext = 32'h0000_7FFF;
      end else if (v < -18'sd32768) begin
         sat16_ext = 32'hFFFF_8000;
      end else begin
         sat16_ext = {{14{v[17]}}, v};
      end
   endfunction

endpackage

>>> sv/gemm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemm_cell: one tile column
// Holds the accumulators of one column, one per row, updates the row named
// by the passing step, and folds that row's value into the running XOR.
// ----------------------------------------------------------------------------
module gemm_cell #(
   parameter int ROWS = 8,
   parameter int COL  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         b_pair,
   input  logic [$clog2(ROWS+1)-1:0] row,
   input  gemm_pkg::step_type  step_in,
   output gemm_pkg::step_type  step_out
);
   import gemm_pkg::*;

   localparam int RW = $clog2(ROWS+1);
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ACC_W-1:0] acc_ff [ROWS];
   step_type         fwd_ff;
   step_type         fwd_in;
   logic [AW-1:0]    ridx;
   logic [ACC_W-1:0] cur;
   logic [ACC_W-1:0] upd;
   logic signed [17:0] psum;

   assign ridx = row[AW-1:0];
   assign cur  = acc_ff[ridx];
   assign psum = 18'(lane_mul(step_in.a_pair[7:0], b_pair[7:0], step_in.fast))
               + 18'(lane_mul(step_in.a_pair[15:8], b_pair[15:8], step_in.fast));

   always_comb begin
      upd = cur;
      unique case (step_in.cmd)
         CMD_ACCUM: upd = cur + sat16_ext(psum);
         CMD_COMP:  if (step_in.comp_ok && step_in.comp_col == 5'(COL)) begin
                       upd = cur + step_in.comp_value;
                    end
         CMD_PANEL: upd = cur;
         CMD_CLEAR: upd = '0;
         default:   upd = cur;
      endcase
   end

   // pass the step on with this row's value folded into the XOR
   always_comb begin
      fwd_in = step_in;
      fwd_in.xor_acc = step_in.xor_acc ^ cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) acc_ff[i] <= '0;
         fwd_ff <= '0;
      end else begin
         if (step_in.valid && row < RW'(ROWS)) begin
            acc_ff[ridx] <= upd;
         end
         fwd_ff <= fwd_in;
      end
   end

   assign step_out = fwd_ff;
endmodule

>>> sv/int8_gemm_tile_xor_digest_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_gemm_tile_xor_digest_top: int8 GEMM tile with XOR digest
// Chain of TILE_COLS column cells; rows enter the chain one per cycle.
// ----------------------------------------------------------------------------
// One command issues its rows into the head of the column chain; busy
// stays high until the last row leaves the chain end. Every row passes
// each column cell once, so each cell has one multiply pair of its own. An
// end-panel command with the digest enabled strobes rsp_valid for one cycle
// as its last row leaves the chain; the receiver cannot stall it.
module int8_gemm_tile_xor_digest_top #(
   parameter int TILE_ROWS = 8,
   parameter int TILE_COLS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_command,
   input  logic [63:0]  req_a_rows_low,
   input  logic [63:0]  req_a_rows_high,
   input  logic [63:0]  req_b_cols_0_3,
   input  logic [63:0]  req_b_cols_4_7,
   input  logic [63:0]  req_b_cols_8_11,
   input  logic [63:0]  req_b_cols_12_15,
   input  logic [3:0]   req_comp_column,
   input  logic signed [31:0] req_comp_value,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic         csr_data,
   output logic         rsp_valid,
   output logic [31:0]  rsp_tile_xor,
   output logic [15:0]  rsp_panel_index
);
   import gemm_pkg::*;

   localparam int RW = $clog2(TILE_ROWS+1);
   localparam int CW = $clog2(TILE_ROWS+TILE_COLS+1);

   logic fast_ff, digest_ff;
   logic [IDX_W-1:0] panel_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff;
   cmd_type cmd_ff;
   logic [63:0] a_lo_ff, a_hi_ff;
   logic [255:0] b_ff;
   logic [3:0] col_ff;
   logic [31:0] cv_ff;
   logic dig_ff;

   step_type head;
   step_type link [TILE_COLS+1];
   logic [RW-1:0] row_pipe [TILE_COLS];
   logic [RW-1:0] row_ff [TILE_COLS];
   logic [RW-1:0] issue_row;
   logic [4:0] arow;
   logic issuing;

   assign issuing   = busy_ff && cnt_ff < CW'(TILE_ROWS);
   assign issue_row = RW'(cnt_ff);
   assign arow      = 5'(issue_row);

   always_comb begin
      head = '0;
      head.valid = issuing;
      head.cmd = cmd_ff;
      head.fast = fast_ff;
      head.comp_value = cv_ff;
      head.comp_col = {1'b0, col_ff};
      head.comp_ok = fast_ff && (32'(col_ff) < 32'(TILE_COLS));
      head.last = issuing && (cnt_ff == CW'(TILE_ROWS-1));
      if (arow < 5'(FIELD_ROWS)) begin
         head.a_pair = (arow < 5'd4) ? a_lo_ff[16*arow[1:0] +: 16]
                                     : a_hi_ff[16*arow[1:0] +: 16];
      end
   end

   assign link[0] = head;

   for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
      logic [15:0] bp;
      if (c < FIELD_COLS) begin : g_b
         assign bp = b_ff[16*c +: 16];
      end else begin : g_z
         assign bp = '0;
      end
      if (c == 0) begin : g_r0
         assign row_pipe[c] = issue_row;
      end else begin : g_rn
         assign row_pipe[c] = row_ff[c-1];
      end
      always_ff @(posedge clock) row_ff[c] <= row_pipe[c];
      gemm_cell #(.ROWS(TILE_ROWS), .COL(c)) u_cell (
         .clock, .reset, .b_pair(bp),
         .row(link[c].valid ? row_pipe[c] : RW'(TILE_ROWS)),
         .step_in(link[c]), .step_out(link[c+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= 1'b0; digest_ff <= 1'b1; panel_ff <= '0;
         busy_ff <= 1'b0; cnt_ff <= '0; dig_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_FAST) fast_ff <= csr_data;
            else digest_ff <= csr_data;
         end
         if (start && !busy_ff) begin
            busy_ff <= 1'b1; cnt_ff <= '0;
            cmd_ff <= cmd_type'(req_command);
            a_lo_ff <= req_a_rows_low; a_hi_ff <= req_a_rows_high;
            b_ff <= {req_b_cols_12_15, req_b_cols_8_11, req_b_cols_4_7,
                     req_b_cols_0_3};
            col_ff <= req_comp_column; cv_ff <= req_comp_value;
            dig_ff <= (cmd_type'(req_command) == CMD_PANEL) && digest_ff;
            if (cmd_type'(req_command) == CMD_PANEL) panel_ff <= panel_ff + 1'b1;
            rsp_panel_index <= panel_ff;
         end else if (busy_ff) begin
            // drop busy when the last row leaves the chain
            if (link[TILE_COLS].valid && link[TILE_COLS].last) busy_ff <= 1'b0;
            else cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // XOR folds over rows as they exit the chain end.
   logic [31:0] fold_ff;
   always_ff @(posedge clock) begin
      if (reset || (start && !busy_ff)) fold_ff <= '0;
      else if (link[TILE_COLS].valid) fold_ff <= fold_ff ^ link[TILE_COLS].xor_acc;
   end

   assign busy = busy_ff;
   assign rsp_valid = busy_ff && link[TILE_COLS].valid && link[TILE_COLS].last && dig_ff;
   assign rsp_tile_xor = fold_ff ^ link[TILE_COLS].xor_acc;

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside an item");
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !link[0].valid) else $error("row issued while idle");
endmodule
